>>> hdl/tq_pkg.sv
// Shared types and codes for the split-array twin queue.
// Used by every module of the block and by its checker; depends on nothing.
package tq_pkg;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [2:0] {
		ST_STORED_FIRST  = 3'd0,
		ST_STORED_SECOND = 3'd1,
		ST_FULL          = 3'd2,
		ST_TAKEN_FIRST   = 3'd3,
		ST_TAKEN_SECOND  = 3'd4,
		ST_EMPTY         = 3'd5
	} status_t;

	typedef struct packed {
		logic               command;
		logic signed [31:0] value;
	} req_item_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] word_out;
	} rsp_item_t;

	// Store access for one transfer: at most one of the two is set.
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_req_t;

endpackage

>>> hdl/split_array_twin_queue.sv
// channel | dir | handshake           | payload
// req     | in  | req_valid/req_stall | req_item_t  (command, value)
// rsp     | out | rsp_valid/rsp_stall | rsp_item_t  (status, word_out)
//
// One request per cycle while req_stall is low; its result reaches rsp via the result stage and the output register.
// Pointer update and the store access, if any, happen at the request transfer;
// the store read data is registered, then the output register holds it.
// arst_n clears both queues; store contents are left as they are.
// A stalled rsp holds; one further request is taken before req_stall rises.
// Depends on tq_pkg, tq_ctrl, tq_mem, tq_out.
module split_array_twin_queue import tq_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int AW = $clog2(DEPTH);

	logic               accept;
	logic               s1_free;
	mem_req_t           mreq;
	logic [AW-1:0]      addr;
	status_t            status;
	logic signed [31:0] rdata_s1;

	assign req_stall = !s1_free;
	assign accept    = req_valid && s1_free;

	tq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (req),
		.mreq   (mreq),
		.addr   (addr),
		.status (status)
	);

	tq_mem #(.DEPTH(DEPTH)) u_mem (
		.clk      (clk),
		.accept   (accept),
		.mreq     (mreq),
		.addr     (addr),
		.wdata    (req.value),
		.rdata_s1 (rdata_s1)
	);

	tq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.status    (status),
		.rdata_s1  (rdata_s1),
		.s1_free   (s1_free),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

>>> hdl/tq_ctrl.sv
// Pointer control for both queues: decides status and store access per transfer.
// Depends on tq_pkg.
module tq_ctrl import tq_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  req_item_t                     item,
	output mem_req_t                      mreq,
	output logic [$clog2(DEPTH)-1:0]      addr,
	output status_t                       status
);

	localparam int AW   = $clog2(DEPTH);
	localparam int TW   = $clog2(DEPTH + 1);
	localparam int HALF = DEPTH / 2;

	logic [AW-1:0] first_head_q, first_head_d;
	logic [AW-1:0] fill_end_q, fill_end_d;
	logic [AW-1:0] second_head_q, second_head_d;
	logic [TW-1:0] second_tail_q, second_tail_d;
	logic [TW-1:0] tail_dec;

	always_comb begin
		first_head_d  = first_head_q;
		fill_end_d    = fill_end_q;
		second_head_d = second_head_q;
		second_tail_d = second_tail_q;
		mreq          = '0;
		addr          = '0;
		status        = ST_EMPTY;
		tail_dec      = (second_tail_q != '0) ? second_tail_q - 1'b1 : second_tail_q;
		if (item.command == CMD_ENQ) begin
			if (second_tail_q == TW'(fill_end_q)) begin
				status = ST_FULL;
			end else if (fill_end_q == AW'(HALF)) begin
				// lower half taken: grow the second queue downward
				second_tail_d = tail_dec;
				addr          = AW'(tail_dec);
				mreq.wr       = 1'b1;
				status        = ST_STORED_SECOND;
			end else begin
				addr       = fill_end_q;
				mreq.wr    = 1'b1;
				fill_end_d = fill_end_q + 1'b1;
				status     = ST_STORED_FIRST;
			end
		end else if (fill_end_q != '0) begin
			addr    = first_head_q;
			mreq.rd = 1'b1;
			status  = ST_TAKEN_FIRST;
			if (AW'(first_head_q + 1'b1) == fill_end_q) begin
				first_head_d = '0;
				fill_end_d   = '0;
			end else begin
				first_head_d = first_head_q + 1'b1;
			end
		end else if (second_tail_q != TW'(DEPTH)) begin
			addr    = second_head_q;
			mreq.rd = 1'b1;
			status  = ST_TAKEN_SECOND;
			if (TW'(second_head_q) == second_tail_q || second_head_q == '0) begin
				second_head_d = AW'(DEPTH - 1);
				second_tail_d = TW'(DEPTH);
			end else begin
				second_head_d = second_head_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_head_q  <= '0;
			fill_end_q    <= '0;
			second_head_q <= AW'(DEPTH - 1);
			second_tail_q <= TW'(DEPTH);
		end else if (accept) begin
			first_head_q  <= first_head_d;
			fill_end_q    <= fill_end_d;
			second_head_q <= second_head_d;
			second_tail_q <= second_tail_d;
		end
	end

endmodule

>>> hdl/tq_mem.sv
// Word store shared by both queues: at most one access per transfer, registered read.
// Depends on tq_pkg.
module tq_mem import tq_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     accept,
	input  mem_req_t                 mreq,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic signed [31:0]       wdata,
	output logic signed [31:0]       rdata_s1
);

	logic signed [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (accept && mreq.wr) begin
			mem_q[addr] <= wdata;
		end
		if (accept && mreq.rd) begin
			rdata_s1 <= mem_q[addr];
		end
	end

endmodule

>>> hdl/tq_out.sv
// Result stage plus output register, so one more transfer is taken while a
// result is held. Depends on tq_pkg.
module tq_out import tq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  status_t            status,
	input  logic signed [31:0] rdata_s1,
	output logic               s1_free,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_item_t          rsp
);

	logic      valid_s1;
	status_t   status_s1;
	logic      advance;
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	assign advance = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign s1_free = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
		end
		if (advance) begin
			rsp_q.status <= status_s1;
			// read data is only meaningful for a take
			rsp_q.word_out <= (status_s1 == ST_TAKEN_FIRST || status_s1 == ST_TAKEN_SECOND) ?
				rdata_s1 : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> hdl/tq_checker.sv
// Port-level checks for split_array_twin_queue, bound to the top level.
// Depends on tq_pkg.
module tq_checker import tq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input req_item_t req,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_item_t rsp
);

	// held result must not move or vanish under stall
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// a stalled request stays offered and unchanged
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("req changed while stalled");

	// requests back up only when the output side is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("req stalled with output free");

	// only a take carries a word
	a_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_TAKEN_FIRST && rsp.status != ST_TAKEN_SECOND
		|-> rsp.word_out == '0)
		else $error("word_out non-zero without a take");

endmodule

bind split_array_twin_queue tq_checker u_tq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
